// File: sv/ttcw_pkg.sv
// Shared types and constants for the text terminal cursor writer.
`default_nettype none

package ttcw_pkg;

	localparam logic [7:0] CODE_BACKSPACE = 8'd8;
	localparam logic [7:0] CODE_NEWLINE   = 8'd10;
	localparam logic [7:0] CODE_RETURN    = 8'd13;
	localparam logic [7:0] CODE_SPACE     = 8'd32;

	localparam logic [6:0] COLS_RESET  = 7'd80;
	localparam logic [6:0] ROWS_RESET  = 7'd25;
	localparam logic [7:0] COLOR_RESET = 8'd7;

	typedef enum logic [1:0] {
		CFG_COLUMNS = 2'd0,
		CFG_ROWS    = 2'd1,
		CFG_COLOR   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [6:0] row;
		logic [6:0] col;
		logic [6:0] top;
	} cursor_t;

	typedef struct packed {
		logic       write_valid;
		logic [6:0] write_row;
		logic [6:0] write_col;
		logic [7:0] write_char;
		logic [7:0] write_color;
		logic       clear_valid;
		logic [6:0] clear_row;
	} cell_req_t;

endpackage

`default_nettype wire

// File: sv/ttcw_step.sv
// Next cursor state and cell/clear requests for one character.
`default_nettype none

module ttcw_step import ttcw_pkg::*; (
	input  wire logic [7:0] char_code,
	input  wire cursor_t    cur,
	input  wire logic [7:0] rows_eff,
	input  wire logic [7:0] cols_eff,
	input  wire logic [7:0] color,
	output cursor_t         nxt,
	output cell_req_t       req
);

	logic [7:0] phys_sum;
	logic [7:0] phys;
	logic [7:0] col_inc;
	logic [7:0] row_inc;
	logic [7:0] top_inc;
	logic [7:0] last_row;
	logic       next_row;

	always_comb begin
		phys_sum = {1'b0, cur.top} + {1'b0, cur.row};
		phys     = (phys_sum >= rows_eff) ? phys_sum - rows_eff : phys_sum;
		col_inc  = {1'b0, cur.col} + 8'd1;
		row_inc  = {1'b0, cur.row} + 8'd1;
		top_inc  = {1'b0, cur.top} + 8'd1;
		last_row = rows_eff - 8'd1;
	end

	always_comb begin
		nxt      = cur;
		req      = '0;
		next_row = 1'b0;
		if (rows_eff != 8'd0) begin
			case (char_code)
				CODE_NEWLINE: begin
					nxt.col  = 7'd0;
					next_row = 1'b1;
				end
				CODE_RETURN: begin
					nxt.col = 7'd0;
				end
				CODE_BACKSPACE: begin
					if (cur.col != 7'd0) begin
						nxt.col         = cur.col - 7'd1;
						req.write_valid = 1'b1;
						req.write_row   = phys[6:0];
						req.write_col   = cur.col - 7'd1;
						req.write_char  = CODE_SPACE;
						req.write_color = color;
					end
				end
				default: begin
					req.write_valid = 1'b1;
					req.write_row   = phys[6:0];
					req.write_col   = cur.col;
					req.write_char  = char_code;
					req.write_color = color;
					if (col_inc >= cols_eff) begin
						nxt.col  = 7'd0;
						next_row = 1'b1;
					end else begin
						nxt.col = col_inc[6:0];
					end
				end
			endcase
			if (next_row) begin
				if (row_inc >= rows_eff) begin
					// Scroll: the old top physical row becomes the new bottom row.
					req.clear_valid = 1'b1;
					req.clear_row   = cur.top;
					nxt.top         = (top_inc >= rows_eff) ? 7'd0 : top_inc[6:0];
					nxt.row         = last_row[6:0];
				end else begin
					nxt.row = row_inc[6:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/text_terminal_cursor_writer_core.sv
// Top level of the text terminal cursor writer: input stage, cursor state and result register.
//
// Channel | Direction | Handshake                  | Word
// in      | in        | in_valid / in_stall        | char_code
// out     | out       | out_valid / out_stall      | write_*, clear_*, cursor_*_out, top_offset
// cfg     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One character per cycle while the output is not stalled; a word leaves the input stage
// as soon as the result register is free. The cursor update is a single adder-and-compare pass
// between the input stage and the result register. Reset selects 80 columns, 25 rows and
// color 7 with the cursor at the origin. A stalled result holds the input stage, which then
// stalls the input. Configuration writes are taken only while both stages are empty.
`default_nettype none

module text_terminal_cursor_writer_core import ttcw_pkg::*; #(
	parameter int MAX_COLS = 100,
	parameter int MAX_ROWS = 75
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_code,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            write_valid,
	output logic [6:0]      write_row,
	output logic [6:0]      write_col,
	output logic [7:0]      write_char,
	output logic [7:0]      write_color,
	output logic            clear_valid,
	output logic [6:0]      clear_row,
	output logic [6:0]      cursor_row_out,
	output logic [6:0]      cursor_col_out,
	output logic [6:0]      top_offset,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam logic [7:0] MaxColsW = 8'(MAX_COLS);
	localparam logic [7:0] MaxRowsW = 8'(MAX_ROWS);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	cell_req_t  req_q;
	cursor_t    cur_out_q;
	cursor_t    cur_q;
	logic [6:0] cols_q;
	logic [6:0] rows_q;
	logic [7:0] color_q;

	logic       advance;
	logic       in_accept;
	logic       cfg_write;
	logic [7:0] cols_eff;
	logic [7:0] rows_eff;
	logic [6:0] cols_new;
	logic [6:0] rows_new;
	logic [7:0] cols_new_eff;
	logic [7:0] rows_new_eff;
	logic [7:0] cols_new_last;
	logic [7:0] rows_new_last;
	cursor_t    cur_clamped;
	cursor_t    cur_next;
	cell_req_t  req_next;

	function automatic logic [7:0] cols_limit(input logic [6:0] raw, input logic [7:0] lim);
		logic [7:0] w;
		w = {1'b0, raw};
		if (w == 8'd0) w = 8'd1;
		if (w > lim) w = lim;
		return w;
	endfunction

	function automatic logic [7:0] rows_limit(input logic [6:0] raw, input logic [7:0] lim);
		logic [7:0] h;
		h = {1'b0, raw};
		if (h > lim) h = lim;
		return h;
	endfunction

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = !valid_s1 && !out_valid_q;
	assign cfg_write = cfg_valid && cfg_ready;

	assign cols_eff = cols_limit(cols_q, MaxColsW);
	assign rows_eff = rows_limit(rows_q, MaxRowsW);

	// Register values as they stand after this cycle's configuration write.
	always_comb begin
		cols_new = cols_q;
		rows_new = rows_q;
		if (cfg_write) begin
			case (cfg_index)
				CFG_COLUMNS: cols_new = cfg_data[6:0];
				CFG_ROWS:    rows_new = cfg_data[6:0];
				default:     ;
			endcase
		end
		cols_new_eff  = cols_limit(cols_new, MaxColsW);
		rows_new_eff  = rows_limit(rows_new, MaxRowsW);
		cols_new_last = cols_new_eff - 8'd1;
		rows_new_last = rows_new_eff - 8'd1;
	end

	always_comb begin
		cur_clamped = cur_q;
		if (rows_new_eff == 8'd0) begin
			cur_clamped = '0;
		end else begin
			if ({1'b0, cur_q.row} >= rows_new_eff) cur_clamped.row = rows_new_last[6:0];
			if ({1'b0, cur_q.col} >= cols_new_eff) cur_clamped.col = cols_new_last[6:0];
			if ({1'b0, cur_q.top} >= rows_new_eff) cur_clamped.top = 7'd0;
		end
	end

	ttcw_step u_step (
		.char_code (char_s1),
		.cur       (cur_q),
		.rows_eff  (rows_eff),
		.cols_eff  (cols_eff),
		.color     (color_q),
		.nxt       (cur_next),
		.req       (req_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			cols_q      <= COLS_RESET;
			rows_q      <= ROWS_RESET;
			color_q     <= COLOR_RESET;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				cols_q <= cols_new;
				rows_q <= rows_new;
				if (cfg_index == CFG_COLOR) color_q <= cfg_data;
				if (cfg_index == CFG_COLUMNS || cfg_index == CFG_ROWS ||
				    cfg_index == CFG_COLOR) begin
					cur_q <= cur_clamped;
				end
			end else if (advance) begin
				cur_q <= cur_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1 <= char_code;
		end
		if (advance) begin
			req_q     <= req_next;
			cur_out_q <= cur_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign write_valid    = req_q.write_valid;
	assign write_row      = req_q.write_row;
	assign write_col      = req_q.write_col;
	assign write_char     = req_q.write_char;
	assign write_color    = req_q.write_color;
	assign clear_valid    = req_q.clear_valid;
	assign clear_row      = req_q.clear_row;
	assign cursor_row_out = cur_out_q.row;
	assign cursor_col_out = cur_out_q.col;
	assign top_offset     = cur_out_q.top;

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rows_eff != 8'd0) |-> ({1'b0, cur_q.row} < rows_eff))
		else $error("cursor row outside usable rows");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ({1'b0, cursor_col_out} < cols_eff))
		else $error("reported cursor column outside grid");

	a_clear_on_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clear_valid) |-> ({1'b0, cursor_row_out} == rows_eff - 8'd1))
		else $error("scroll did not leave cursor on last row");

	a_no_rows_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && rows_eff == 8'd0) |=> (!write_valid && !clear_valid))
		else $error("request issued with no usable rows");

endmodule

`default_nettype wire
